[src/pdg_pkg.sv]
`timescale 1ns / 1ps
package pdg_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 17;

    localparam logic signed [31:0] FLOOR_Q = -32'sd655360;
    localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [20:0]        frame_dt;
        logic               last_in;
    } pdg_in_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_pos_z;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic signed [31:0] new_vel_z;
        logic               last_out;
    } pdg_out_t;

    // Side data that travels with an item through the root and divide stages.
    typedef struct packed {
        logic signed [31:0] npx;
        logic signed [31:0] npy;
        logic signed [31:0] npz;
        logic signed [31:0] nvz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [31:0]        mx;
        logic [31:0]        my;
        logic [20:0]        dt;
        logic               last;
    } pdg_carry_t;

    function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'(S32_MAX))
            r = S32_MAX;
        else if (v < 40'(S32_MIN))
            r = S32_MIN;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[src/pdg_isqrt.sv]
`timescale 1ns / 1ps
module pdg_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [63:0]        radicand,
    input  pdg_pkg::pdg_carry_t in_carry,
    output logic               out_valid,
    output logic [31:0]        root,
    output pdg_pkg::pdg_carry_t out_carry
);
    import pdg_pkg::*;

    typedef struct packed {
        logic [63:0] rad;
        logic [34:0] rem;
        logic [31:0] root;
        pdg_carry_t  carry;
    } sq_stage_t;

    logic [SQRT_STEPS-1:0] valid_reg;
    logic [SQRT_STEPS-1:0] valid_in;
    sq_stage_t             stage_reg [SQRT_STEPS];
    sq_stage_t             stage_in  [SQRT_STEPS];
    sq_stage_t             stage_next [SQRT_STEPS];

    // One result bit per stage: two radicand bits enter the remainder each step.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        if (k == 0) begin : g_head
            assign valid_in[k] = in_valid;
            assign stage_in[k] = '{rad: radicand, rem: '0, root: '0, carry: in_carry};
        end else begin : g_body
            assign valid_in[k] = valid_reg[k-1];
            assign stage_in[k] = stage_reg[k-1];
        end

        always_comb
        begin
            logic [34:0] shifted;
            logic [34:0] trial;
            shifted = {stage_in[k].rem[32:0], stage_in[k].rad[63:62]};
            trial   = {1'b0, stage_in[k].root, 2'b01};
            stage_next[k].rad   = {stage_in[k].rad[61:0], 2'b00};
            stage_next[k].carry = stage_in[k].carry;
            if (shifted >= trial)
            begin
                stage_next[k].rem  = shifted - trial;
                stage_next[k].root = {stage_in[k].root[30:0], 1'b1};
            end
            else
            begin
                stage_next[k].rem  = shifted;
                stage_next[k].root = {stage_in[k].root[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (adv)
                valid_reg[k] <= valid_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                stage_reg[k] <= stage_next[k];
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign root      = stage_reg[SQRT_STEPS-1].root;
    assign out_carry = stage_reg[SQRT_STEPS-1].carry;

endmodule

[src/pdg_udiv.sv]
`timescale 1ns / 1ps
module pdg_udiv (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [31:0]        mag,
    input  pdg_pkg::pdg_carry_t in_carry,
    output logic               out_valid,
    output logic [16:0]        quo_x,
    output logic [16:0]        quo_y,
    output pdg_pkg::pdg_carry_t out_carry
);
    import pdg_pkg::*;

    // Divides |v| * 65536 by mag for x and y. Since |v| <= mag the quotient
    // fits in 17 bits, so the upper numerator bits start out as the remainder.
    typedef struct packed {
        logic [33:0] rem_x;
        logic [33:0] rem_y;
        logic        bit_x;
        logic        bit_y;
        logic [16:0] q_x;
        logic [16:0] q_y;
        logic [31:0] mag;
        pdg_carry_t  carry;
    } dv_stage_t;

    logic [DIV_STEPS-1:0] valid_reg;
    logic [DIV_STEPS-1:0] valid_in;
    dv_stage_t            stage_reg  [DIV_STEPS];
    dv_stage_t            stage_in   [DIV_STEPS];
    dv_stage_t            stage_next [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        if (k == 0) begin : g_head
            assign valid_in[k] = in_valid;
            assign stage_in[k] = '{rem_x: {3'b000, in_carry.mx[31:1]},
                                   rem_y: {3'b000, in_carry.my[31:1]},
                                   bit_x: in_carry.mx[0],
                                   bit_y: in_carry.my[0],
                                   q_x: '0, q_y: '0, mag: mag, carry: in_carry};
        end else begin : g_body
            assign valid_in[k] = valid_reg[k-1];
            assign stage_in[k] = stage_reg[k-1];
        end

        always_comb
        begin
            logic [33:0] sh_x;
            logic [33:0] sh_y;
            logic [33:0] dvs;
            sh_x = {stage_in[k].rem_x[32:0], stage_in[k].bit_x};
            sh_y = {stage_in[k].rem_y[32:0], stage_in[k].bit_y};
            dvs  = {2'b00, stage_in[k].mag};
            stage_next[k] = stage_in[k];
            stage_next[k].bit_x = 1'b0;
            stage_next[k].bit_y = 1'b0;
            if (sh_x >= dvs)
            begin
                stage_next[k].rem_x = sh_x - dvs;
                stage_next[k].q_x   = {stage_in[k].q_x[15:0], 1'b1};
            end
            else
            begin
                stage_next[k].rem_x = sh_x;
                stage_next[k].q_x   = {stage_in[k].q_x[15:0], 1'b0};
            end
            if (sh_y >= dvs)
            begin
                stage_next[k].rem_y = sh_y - dvs;
                stage_next[k].q_y   = {stage_in[k].q_y[15:0], 1'b1};
            end
            else
            begin
                stage_next[k].rem_y = sh_y;
                stage_next[k].q_y   = {stage_in[k].q_y[15:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (adv)
                valid_reg[k] <= valid_in[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                stage_reg[k] <= stage_next[k];
        end
    end

    // A zero velocity has a zero magnitude; its unit vector is zero.
    assign out_valid = valid_reg[DIV_STEPS-1];
    assign quo_x     = (stage_reg[DIV_STEPS-1].mag == '0) ? '0 : stage_reg[DIV_STEPS-1].q_x;
    assign quo_y     = (stage_reg[DIV_STEPS-1].mag == '0) ? '0 : stage_reg[DIV_STEPS-1].q_y;
    assign out_carry = stage_reg[DIV_STEPS-1].carry;

endmodule

[src/particle_drag_gravity_step_top.sv]
`timescale 1ns / 1ps
// Channel    Direction  Handshake                  Payload
// particle   in         particle_valid / _stall    pdg_in_t (position, velocity, dt, last)
// result     out        result_valid / _stall      pdg_out_t (new position, velocity, last)
// config     in         APB psel/penable/pready    five registers at 4*i
//
// One item enters per cycle while no result is stalled; each passes the input
// stages, the 32 square root stages, the 17 divide stages after them and the output stages.
// Reset clears all valid bits and the registers; nothing else needs clearing.
// A stalled result holds the whole pipeline, and particle_stall rises with it.
module particle_drag_gravity_step_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              particle_valid,
    output logic              particle_stall,
    input  pdg_pkg::pdg_in_t  particle,
    output logic              result_valid,
    input  logic              result_stall,
    output pdg_pkg::pdg_out_t result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import pdg_pkg::*;

    localparam logic [2:0] REG_DRAG    = 3'd0;
    localparam logic [2:0] REG_FORCE_X = 3'd1;
    localparam logic [2:0] REG_FORCE_Y = 3'd2;
    localparam logic [2:0] REG_GRAVITY = 3'd3;
    localparam logic [2:0] REG_BOUNCE  = 3'd4;

    logic [30:0]        drag_coeff_reg;
    logic signed [31:0] force_x_reg;
    logic signed [31:0] force_y_reg;
    logic signed [31:0] gravity_z_reg;
    logic               bounce_enable_reg;

    logic adv;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drag_coeff_reg    <= '0;
            force_x_reg       <= '0;
            force_y_reg       <= '0;
            gravity_z_reg     <= '0;
            bounce_enable_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (paddr[4:2])
                REG_DRAG:    drag_coeff_reg    <= pwdata[30:0];
                REG_FORCE_X: force_x_reg       <= pwdata;
                REG_FORCE_Y: force_y_reg       <= pwdata;
                REG_GRAVITY: gravity_z_reg     <= pwdata;
                REG_BOUNCE:  bounce_enable_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_DRAG:    prdata = {1'b0, drag_coeff_reg};
            REG_FORCE_X: prdata = force_x_reg;
            REG_FORCE_Y: prdata = force_y_reg;
            REG_GRAVITY: prdata = gravity_z_reg;
            REG_BOUNCE:  prdata = {31'b0, bounce_enable_reg};
            default:     prdata = '0;
        endcase
    end

    assign adv            = !(result_valid && result_stall);
    assign particle_stall = !adv;

    // Stage 1: input register.
    logic    s1_valid_reg;
    pdg_in_t s1_reg;

    // Stage 2: squares, gravity product, positions.
    logic               s2_valid_reg;
    logic [63:0]        sqx_reg, sqy_reg, sqz_reg;
    logic [36:0]        gdv_reg;
    logic               gneg_reg;
    logic signed [31:0] vz2_reg;
    pdg_carry_t         c2_reg;

    // Stage 3: radicand and new z velocity before bounce.
    logic        s3_valid_reg;
    logic [63:0] rad_reg;
    pdg_carry_t  c3_reg;

    logic [31:0] s1_mx, s1_my, s1_mz, s1_mg;
    logic [52:0] s1_gprod;

    always_comb
    begin
        s1_mx    = s1_reg.vel_x[31] ? 32'(-s1_reg.vel_x) : s1_reg.vel_x;
        s1_my    = s1_reg.vel_y[31] ? 32'(-s1_reg.vel_y) : s1_reg.vel_y;
        s1_mz    = s1_reg.vel_z[31] ? 32'(-s1_reg.vel_z) : s1_reg.vel_z;
        s1_mg    = gravity_z_reg[31] ? 32'(-gravity_z_reg) : gravity_z_reg;
        s1_gprod = 53'(s1_mg) * 53'(s1_reg.frame_dt);
    end

    logic signed [39:0] s2_nvz;
    pdg_carry_t         c3_next;

    always_comb
    begin
        s2_nvz = gneg_reg ? 40'(vz2_reg) + 40'(gdv_reg) : 40'(vz2_reg) - 40'(gdv_reg);
        c3_next     = c2_reg;
        c3_next.nvz = sat40(s2_nvz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= particle_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= particle;

            sqx_reg    <= 64'(s1_mx) * 64'(s1_mx);
            sqy_reg    <= 64'(s1_my) * 64'(s1_my);
            sqz_reg    <= 64'(s1_mz) * 64'(s1_mz);
            gdv_reg    <= s1_gprod[52:16];
            gneg_reg   <= gravity_z_reg[31];
            vz2_reg    <= s1_reg.vel_z;
            c2_reg.npx <= sat40(40'(s1_reg.pos_x) + 40'(s1_reg.vel_x));
            c2_reg.npy <= sat40(40'(s1_reg.pos_y) + 40'(s1_reg.vel_y));
            c2_reg.npz <= sat40(40'(s1_reg.pos_z) + 40'(s1_reg.vel_z));
            c2_reg.nvz <= '0;
            c2_reg.vx  <= s1_reg.vel_x;
            c2_reg.vy  <= s1_reg.vel_y;
            c2_reg.mx  <= s1_mx;
            c2_reg.my  <= s1_my;
            c2_reg.dt  <= s1_reg.frame_dt;
            c2_reg.last <= s1_reg.last_in;

            rad_reg    <= sqx_reg + sqy_reg + sqz_reg;
            c3_reg     <= c3_next;
        end
    end

    logic        sq_valid;
    logic [31:0] sq_root;
    pdg_carry_t  sq_carry;

    pdg_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s3_valid_reg),
        .radicand  (rad_reg),
        .in_carry  (c3_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_carry (sq_carry)
    );

    logic        dv_valid;
    logic [16:0] ex, ey;
    pdg_carry_t  dv_carry;

    pdg_udiv u_udiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .mag       (sq_root),
        .in_carry  (sq_carry),
        .out_valid (dv_valid),
        .quo_x     (ex),
        .quo_y     (ey),
        .out_carry (dv_carry)
    );

    // Drag, acceleration, velocity step and output stages.
    logic               d1_valid_reg, d2_valid_reg, d3_valid_reg;
    logic [31:0]        dragx_reg, dragy_reg;
    pdg_carry_t         d1_carry_reg, d2_carry_reg, d3_carry_reg;
    logic signed [33:0] ax_reg, ay_reg;
    logic signed [38:0] dvx_reg, dvy_reg;
    logic               out_valid_reg;
    pdg_out_t           out_reg;

    logic [47:0]        dx_prod, dy_prod;
    logic signed [33:0] ax_next, ay_next;
    logic [32:0]        ax_mag, ay_mag;
    logic [53:0]        vx_prod, vy_prod;
    logic signed [31:0] nvz_sat;
    logic signed [31:0] nvz_out;

    always_comb
    begin
        dx_prod = 48'(drag_coeff_reg) * 48'(ex);
        dy_prod = 48'(drag_coeff_reg) * 48'(ey);

        ax_next = d1_carry_reg.vx[31] ? 34'(force_x_reg) + 34'(dragx_reg)
                                      : 34'(force_x_reg) - 34'(dragx_reg);
        ay_next = d1_carry_reg.vy[31] ? 34'(force_y_reg) + 34'(dragy_reg)
                                      : 34'(force_y_reg) - 34'(dragy_reg);

        ax_mag  = ax_reg[33] ? 33'(-ax_reg) : ax_reg[32:0];
        ay_mag  = ay_reg[33] ? 33'(-ay_reg) : ay_reg[32:0];
        vx_prod = 54'(ax_mag) * 54'(d2_carry_reg.dt);
        vy_prod = 54'(ay_mag) * 54'(d2_carry_reg.dt);

        nvz_sat = d3_carry_reg.nvz;
        if (bounce_enable_reg && d3_carry_reg.npz < FLOOR_Q)
            nvz_out = (nvz_sat == S32_MIN) ? S32_MAX : -nvz_sat;
        else
            nvz_out = nvz_sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_valid_reg  <= 1'b0;
            d2_valid_reg  <= 1'b0;
            d3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            d1_valid_reg  <= dv_valid;
            d2_valid_reg  <= d1_valid_reg;
            d3_valid_reg  <= d2_valid_reg;
            out_valid_reg <= d3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dragx_reg    <= dx_prod[47:16];
            dragy_reg    <= dy_prod[47:16];
            d1_carry_reg <= dv_carry;

            ax_reg       <= ax_next;
            ay_reg       <= ay_next;
            d2_carry_reg <= d1_carry_reg;

            dvx_reg      <= ax_reg[33] ? -39'(vx_prod[53:16]) : 39'(vx_prod[53:16]);
            dvy_reg      <= ay_reg[33] ? -39'(vy_prod[53:16]) : 39'(vy_prod[53:16]);
            d3_carry_reg <= d2_carry_reg;

            out_reg.new_pos_x <= d3_carry_reg.npx;
            out_reg.new_pos_y <= d3_carry_reg.npy;
            out_reg.new_pos_z <= d3_carry_reg.npz;
            out_reg.new_vel_x <= sat40(40'(d3_carry_reg.vx) + 40'(dvx_reg));
            out_reg.new_vel_y <= sat40(40'(d3_carry_reg.vy) + 40'(dvy_reg));
            out_reg.new_vel_z <= nvz_out;
            out_reg.last_out  <= d3_carry_reg.last;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // A unit vector component never exceeds 1.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid |-> (ex <= 17'h10000 && ey <= 17'h10000))
        else $error("unit component above one");

    // A waiting result freezes the pipeline and blocks new items.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> ($stable(d3_valid_reg) && $stable(dv_valid)))
        else $error("pipeline moved while result was stalled");

    // An accepted item occupies the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (particle_valid && !particle_stall) |=> s1_valid_reg)
        else $error("accepted item lost at entry");

    // Bounce off: the z velocity leaves exactly as the gravity stage made it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (adv && d3_valid_reg && !bounce_enable_reg) |=> (result.new_vel_z == $past(nvz_sat)))
        else $error("z velocity changed without bounce");

endmodule
